>>> src/ihb_pkg.sv
// ----------------------------------------------------------------------------
// ihb_pkg
// Types and constants shared by the IPv4 header builder modules.
// ----------------------------------------------------------------------------
package ihb_pkg;

	localparam int unsigned AddrW    = 32;
	localparam int unsigned HwordW   = 16;
	localparam int unsigned ProtoW   = 8;
	localparam int unsigned WordIdxW = 4;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned SumW     = 20;
	localparam int unsigned PsumW    = 18;

	localparam int unsigned QDepth = 2;
	localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	localparam logic [HwordW-1:0] VerIhlTos  = 16'h4500;
	localparam logic [ProtoW-1:0] TtlVal     = 8'd64;
	localparam logic [HwordW-1:0] HdrBytes   = 16'd20;
	localparam logic [HwordW-1:0] IdentReset = 16'd1;
	localparam logic [HwordW-1:0] FragZero   = 16'h0000;

	// header word positions
	localparam logic [WordIdxW-1:0] W_VER     = 4'd0;
	localparam logic [WordIdxW-1:0] W_LEN     = 4'd1;
	localparam logic [WordIdxW-1:0] W_IDENT   = 4'd2;
	localparam logic [WordIdxW-1:0] W_FRAG    = 4'd3;
	localparam logic [WordIdxW-1:0] W_TTL     = 4'd4;
	localparam logic [WordIdxW-1:0] W_CSUM    = 4'd5;
	localparam logic [WordIdxW-1:0] W_SRC_HI  = 4'd6;
	localparam logic [WordIdxW-1:0] W_SRC_LO  = 4'd7;
	localparam logic [WordIdxW-1:0] W_DST_HI  = 4'd8;
	localparam logic [WordIdxW-1:0] W_DST_LO  = 4'd9;
	localparam logic [WordIdxW-1:0] LastIdx   = W_DST_LO;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_LOCAL   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_MASK    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_GATEWAY = 2'd2;

	typedef struct packed {
		logic [AddrW-1:0]  dest_address;
		logic [ProtoW-1:0] protocol_number;
		logic [HwordW-1:0] payload_length;
	} req_t;

	typedef struct packed {
		logic [HwordW-1:0]   header_word;
		logic [WordIdxW-1:0] word_index;
		logic [AddrW-1:0]    next_hop;
		logic                last_word;
	} rsp_t;

	typedef struct packed {
		logic [AddrW-1:0] local_address;
		logic [AddrW-1:0] subnet_mask;
		logic [AddrW-1:0] gateway_address;
	} cfg_t;

	typedef struct packed {
		logic [AddrW-1:0]  dest;
		logic [AddrW-1:0]  hop;
		logic [HwordW-1:0] total_len;
		logic [HwordW-1:0] ident;
		logic [ProtoW-1:0] proto;
		logic [HwordW-1:0] csum;
	} hdr_t;

endpackage

>>> src/ihb_front.sv
// ----------------------------------------------------------------------------
// ihb_front
// Two-stage request pipeline: length, identification, next hop and the
// ones-complement header checksum.
// ----------------------------------------------------------------------------
module ihb_front import ihb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic push,
	input  req_t req,
	output logic full,
	output logic hdr_valid,
	output hdr_t hdr,
	input  logic hdr_ready
);

	logic              adv1, adv2, accept;
	logic [HwordW-1:0] ident_q;

	logic              v_s1;
	logic [AddrW-1:0]  dst_s1, hop_s1;
	logic [ProtoW-1:0] proto_s1;
	logic [HwordW-1:0] tl_s1, id_s1;
	logic [PsumW-1:0]  psum_s1;

	logic              v_s2;
	logic [AddrW-1:0]  dst_s2, hop_s2;
	logic [ProtoW-1:0] proto_s2;
	logic [HwordW-1:0] tl_s2, id_s2;
	logic [SumW-1:0]   sum_s2;

	logic [HwordW-1:0] tl_d;
	logic [AddrW-1:0]  hop_d;
	logic [PsumW-1:0]  psum_d;
	logic [SumW-1:0]   sum_d;
	logic [HwordW:0]   fold1;
	logic [HwordW-1:0] fold2;

	assign adv2   = !v_s2 || hdr_ready;
	assign adv1   = !v_s1 || adv2;
	assign full   = !adv1;
	assign accept = push && adv1;

	assign tl_d  = req.payload_length + HdrBytes;
	assign hop_d = ((req.dest_address & cfg.subnet_mask) !=
	                (cfg.local_address & cfg.subnet_mask)) ?
	               cfg.gateway_address : req.dest_address;
	assign psum_d = PsumW'(cfg.local_address[31:16]) + PsumW'(cfg.local_address[15:0]) +
	                PsumW'(req.dest_address[31:16]) + PsumW'(req.dest_address[15:0]);

	assign sum_d = SumW'(psum_s1) + SumW'(tl_s1) + SumW'(id_s1) + SumW'(VerIhlTos) +
	               SumW'({TtlVal, proto_s1});

	// end-around carry, twice covers the 20-bit sum
	assign fold1 = {1'b0, sum_s2[HwordW-1:0]} + (HwordW+1)'(sum_s2[SumW-1:HwordW]);
	assign fold2 = fold1[HwordW-1:0] + HwordW'(fold1[HwordW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= IdentReset;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (accept) begin
				ident_q <= ident_q + 16'd1;
			end
			if (adv1) begin
				v_s1 <= accept;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dst_s1   <= req.dest_address;
			proto_s1 <= req.protocol_number;
			tl_s1    <= tl_d;
			id_s1    <= ident_q;
			hop_s1   <= hop_d;
			psum_s1  <= psum_d;
		end
		if (adv2 && v_s1) begin
			dst_s2   <= dst_s1;
			proto_s2 <= proto_s1;
			tl_s2    <= tl_s1;
			id_s2    <= id_s1;
			hop_s2   <= hop_s1;
			sum_s2   <= sum_d;
		end
	end

	assign hdr_valid     = v_s2;
	assign hdr.dest      = dst_s2;
	assign hdr.hop       = hop_s2;
	assign hdr.total_len = tl_s2;
	assign hdr.ident     = id_s2;
	assign hdr.proto     = proto_s2;
	assign hdr.csum      = ~fold2;

endmodule

>>> src/ihb_queue.sv
// ----------------------------------------------------------------------------
// ihb_queue
// Short queue of prepared headers between the front pipeline and the
// word sequencer.
// ----------------------------------------------------------------------------
module ihb_queue import ihb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  hdr_t wr_data,
	output logic full,
	input  logic rd_en,
	output hdr_t rd_data,
	output logic empty
);

	hdr_t             entry_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full    = (count_q == QCntW'(QDepth));
	assign empty   = (count_q == '0);
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + QCntW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - QCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full)) else $error("header queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && empty)) else $error("header queue read while empty");

endmodule

>>> src/ihb_back.sv
// ----------------------------------------------------------------------------
// ihb_back
// Word sequencer: walks the head header through its ten words into the
// output register.
// ----------------------------------------------------------------------------
module ihb_back import ihb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [AddrW-1:0] local_address,
	input  logic             hdr_valid,
	input  hdr_t             hdr,
	output logic             hdr_pop,
	output logic             empty,
	input  logic             pop,
	output rsp_t             rsp
);

	logic [WordIdxW-1:0] idx_q;
	logic                out_v_q;
	rsp_t                rsp_q;
	logic                load;
	logic [HwordW-1:0]   word_d;

	assign load    = hdr_valid && (!out_v_q || pop);
	assign hdr_pop = load && (idx_q == LastIdx);
	assign empty   = !out_v_q;
	assign rsp     = rsp_q;

	always_comb begin
		case (idx_q)
			W_VER:    word_d = VerIhlTos;
			W_LEN:    word_d = hdr.total_len;
			W_IDENT:  word_d = hdr.ident;
			W_FRAG:   word_d = FragZero;
			W_TTL:    word_d = {TtlVal, hdr.proto};
			W_CSUM:   word_d = hdr.csum;
			W_SRC_HI: word_d = local_address[31:16];
			W_SRC_LO: word_d = local_address[15:0];
			W_DST_HI: word_d = hdr.dest[31:16];
			W_DST_LO: word_d = hdr.dest[15:0];
			default:  word_d = FragZero;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= W_VER;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= (idx_q == LastIdx) ? W_VER : idx_q + WordIdxW'(1);
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.header_word <= word_d;
			rsp_q.word_index  <= idx_q;
			rsp_q.next_hop    <= hdr.hop;
			rsp_q.last_word   <= (idx_q == LastIdx);
		end
	end

	a_mid_header_present: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != W_VER) |-> hdr_valid) else $error("header left the queue mid-sequence");

	a_words_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && pop && !rsp_q.last_word) |=>
		(out_v_q && rsp_q.word_index == $past(rsp_q.word_index) + WordIdxW'(1)))
		else $error("header word sequence broken");

endmodule

>>> src/ipv4_header_builder.sv
// ----------------------------------------------------------------------------
// ipv4_header_builder
// Builds 20-byte IPv4 headers, one 16-bit word per pop, with next hop.
// ----------------------------------------------------------------------------
// usage
//   request side: push a word (dest_address, protocol_number, payload_length)
//   while full is low. result side: while empty is low the port rsp holds the
//   oldest header word; pop takes it. each request yields ten words, index 0
//   to 9, last_word set on index 9, every word carrying the same next hop.
//   config: wr_en with wr_index 0 local, 1 mask, 2 gateway; index 3 ignored.
//   write only while no request is in flight.
// flow
//   a header's first word passes stage 1, stage 2, the header queue and the
//   output register. while pop is high one word per cycle leaves that single
//   register, so a header occupies it for ten words; requests can arrive back
//   to back, held in a two-stage front pipeline plus a two-entry header queue.
// reset
//   config registers clear to zero, identification counter starts at one.
// stall
//   with pop low the current word holds; the queue fills and then full rises.
// ----------------------------------------------------------------------------
module ipv4_header_builder import ihb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  req_t               req,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output rsp_t               rsp,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [AddrW-1:0]   wr_data
);

	cfg_t cfg_q;
	logic front_valid, q_full, q_empty, q_pop;
	hdr_t front_hdr, q_hdr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_LOCAL:   cfg_q.local_address   <= wr_data;
				CFG_MASK:    cfg_q.subnet_mask     <= wr_data;
				CFG_GATEWAY: cfg_q.gateway_address <= wr_data;
				default: ;
			endcase
		end
	end

	ihb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.req       (req),
		.full      (full),
		.hdr_valid (front_valid),
		.hdr       (front_hdr),
		.hdr_ready (!q_full)
	);

	ihb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid && !q_full),
		.wr_data (front_hdr),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_hdr),
		.empty   (q_empty)
	);

	ihb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.local_address (cfg_q.local_address),
		.hdr_valid     (!q_empty),
		.hdr           (q_hdr),
		.hdr_pop       (q_pop),
		.empty         (empty),
		.pop           (pop),
		.rsp           (rsp)
	);

endmodule
